>>> design/ttwm_pkg.sv
`timescale 1ns / 1ps

package ttwm_pkg;

  // Coordinate and pipeline sizing
  localparam int COORD_BITS    = 12;
  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_LEN      = 24;
  localparam int NUM_CELLS     = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;
  localparam int IDX_BITS      = $clog2(ATAN_LEN);

  // CORDIC datapath: magnitude * gain stays below 2^(COORD_BITS+FRAC_BITS+2)
  localparam int FRAC_BITS = 16;
  localparam int CW        = COORD_BITS + FRAC_BITS + 3;
  localparam int ZW        = 19;
  localparam int QUARTER   = 65536;
  localparam int Q_BITS    = FRAC_BITS + 1;

  // Level and square root sizing
  localparam int LVL_BITS   = 8;
  localparam int LVL_MAX    = (1 << LVL_BITS) - 1;
  localparam int SQRT_STEPS = LVL_BITS;
  localparam int RAD_BITS   = 2 * LVL_BITS;
  localparam int T_BITS     = RAD_BITS + 2;
  localparam int SQ_BITS    = 2 * COORD_BITS;
  localparam int SUM_BITS   = SQ_BITS + 1;

  // Configuration register indexes
  localparam int CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_X   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_Y   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LOW_THRESH = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WARM_FLOOR = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COOL_FLOOR = 3'd4;

  // Configuration reset values
  localparam logic [COORD_BITS-1:0] CENTER_RST     = COORD_BITS'(255);
  localparam logic [LVL_BITS-1:0]   LOW_THRESH_RST = LVL_BITS'(30);
  localparam logic [LVL_BITS-1:0]   WARM_FLOOR_RST = LVL_BITS'(10);
  localparam logic [LVL_BITS-1:0]   COOL_FLOOR_RST = LVL_BITS'(5);

  // Data handed from cell to cell
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic [RAD_BITS-1:0]  rem;
    logic [LVL_BITS-1:0]  root;
    logic                 sat;
    logic                 dy_neg;
    logic                 ax_zero;
    logic                 ay_zero;
  } cell_t;

  // Arctangent of 2^-i as a Q16 fraction of a quarter turn
  function automatic logic signed [ZW-1:0] atan_q16(input logic [IDX_BITS-1:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      5'd0:    v = ZW'(32768);
      5'd1:    v = ZW'(19344);
      5'd2:    v = ZW'(10221);
      5'd3:    v = ZW'(5188);
      5'd4:    v = ZW'(2604);
      5'd5:    v = ZW'(1303);
      5'd6:    v = ZW'(652);
      5'd7:    v = ZW'(326);
      5'd8:    v = ZW'(163);
      5'd9:    v = ZW'(81);
      5'd10:   v = ZW'(41);
      5'd11:   v = ZW'(20);
      5'd12:   v = ZW'(10);
      5'd13:   v = ZW'(5);
      5'd14:   v = ZW'(3);
      5'd15:   v = ZW'(1);
      5'd16:   v = ZW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> design/ttwm_front.sv
`timescale 1ns / 1ps

module ttwm_front import ttwm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  logic                  valid_i,
  input  logic [COORD_BITS-1:0] touch_x_i,
  input  logic [COORD_BITS-1:0] touch_y_i,
  input  logic [COORD_BITS-1:0] center_x_i,
  input  logic [COORD_BITS-1:0] center_y_i,
  output logic                  valid_o,
  output cell_t                 data_o
);

  logic signed [COORD_BITS:0] dx, dy;
  logic [COORD_BITS-1:0]      ax, ay;
  logic [COORD_BITS-1:0]      ax_q, ay_q;
  logic [SQ_BITS-1:0]         sqx_q, sqy_q;
  logic                       dy_neg_q;
  logic                       v1_q, v2_q;
  logic [SUM_BITS-1:0]        sum;
  cell_t                      cell_d, cell_q;

  // Offsets from center and their magnitudes
  always_comb begin
    dx = $signed({1'b0, touch_x_i}) - $signed({1'b0, center_x_i});
    dy = $signed({1'b0, touch_y_i}) - $signed({1'b0, center_y_i});
    ax = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
    ay = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
  end

  // Squared distance and CORDIC start vector
  always_comb begin
    sum            = SUM_BITS'(sqx_q) + SUM_BITS'(sqy_q);
    cell_d.x       = $signed(CW'({ax_q, {FRAC_BITS{1'b0}}}));
    cell_d.y       = $signed(CW'({ay_q, {FRAC_BITS{1'b0}}}));
    cell_d.z       = '0;
    cell_d.rem     = sum[RAD_BITS-1:0];
    cell_d.root    = '0;
    cell_d.sat     = |sum[SUM_BITS-1:RAD_BITS];
    cell_d.dy_neg  = dy_neg_q;
    cell_d.ax_zero = (ax_q == '0);
    cell_d.ay_zero = (ay_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ax_q     <= ax;
      ay_q     <= ay;
      sqx_q    <= SQ_BITS'(ax) * SQ_BITS'(ax);
      sqy_q    <= SQ_BITS'(ay) * SQ_BITS'(ay);
      dy_neg_q <= dy[COORD_BITS];
      cell_q   <= cell_d;
    end
  end

  assign valid_o = v2_q;
  assign data_o  = cell_q;

endmodule

>>> design/ttwm_cell.sv
`timescale 1ns / 1ps

module ttwm_cell import ttwm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic [IDX_BITS-1:0] idx_i,
  input  logic                valid_i,
  input  cell_t               data_i,
  output logic                valid_o,
  output cell_t               data_o
);

  logic signed [CW-1:0] xs, ys;
  logic [IDX_BITS-1:0]  k;
  logic [T_BITS-1:0]    t, rem_ext;
  cell_t                cell_d, cell_q;
  logic                 valid_q;

  // One CORDIC rotation and, in the first SQRT_STEPS cells, one square root digit
  always_comb begin
    cell_d  = data_i;
    xs      = $signed(data_i.x) >>> idx_i;
    ys      = $signed(data_i.y) >>> idx_i;
    if (!data_i.y[CW-1]) begin
      cell_d.x = data_i.x + ys;
      cell_d.y = data_i.y - xs;
      cell_d.z = data_i.z + atan_q16(idx_i);
    end else begin
      cell_d.x = data_i.x - ys;
      cell_d.y = data_i.y + xs;
      cell_d.z = data_i.z - atan_q16(idx_i);
    end
    // trial digit 2^k: (r + 2^k)^2 - r^2 = r*2^(k+1) + 4^k
    k       = IDX_BITS'(SQRT_STEPS - 1) - idx_i;
    t       = (T_BITS'(data_i.root) << (k + 1'b1)) + (T_BITS'(1) << {k, 1'b0});
    rem_ext = T_BITS'(data_i.rem);
    if ((idx_i < IDX_BITS'(SQRT_STEPS)) && (rem_ext >= t)) begin
      cell_d.rem  = RAD_BITS'(rem_ext - t);
      cell_d.root = data_i.root | (LVL_BITS'(1) << k);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      cell_q <= cell_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = cell_q;

endmodule

>>> design/ttwm_back.sv
`timescale 1ns / 1ps

module ttwm_back import ttwm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic                valid_i,
  input  cell_t               data_i,
  input  logic [LVL_BITS-1:0] low_threshold_i,
  input  logic [LVL_BITS-1:0] warm_floor_i,
  input  logic [LVL_BITS-1:0] cool_floor_i,
  output logic                valid_o,
  output logic [LVL_BITS-1:0] warm_level_o,
  output logic [LVL_BITS-1:0] cool_level_o,
  output logic [LVL_BITS-1:0] brightness_o
);

  localparam int PB = Q_BITS + LVL_BITS;
  localparam int MB = 2 * LVL_BITS;

  logic [Q_BITS-1:0]   f;
  logic [PB-1:0]       fprod;
  logic [LVL_BITS-1:0] chan, bright;
  logic [LVL_BITS-1:0] warm_raw_q, cool_raw_q, bright1_q, bright2_q;
  logic [MB-1:0]       pw_q, pc_q;
  logic [MB:0]         qw_full, qc_full;
  logic [LVL_BITS-1:0] qw, qc;
  logic                v1_q, v2_q, v3_q;
  logic [LVL_BITS-1:0] warm_q, cool_q, bright3_q;

  // Angle clamp, axis cases and channel value
  always_comb begin
    if (data_i.ay_zero) begin
      f = '0;
    end else if (data_i.ax_zero) begin
      f = Q_BITS'(QUARTER);
    end else if (data_i.z[ZW-1]) begin
      f = '0;
    end else if ($signed(data_i.z) > $signed(ZW'(QUARTER))) begin
      f = Q_BITS'(QUARTER);
    end else begin
      f = data_i.z[Q_BITS-1:0];
    end
    // 255*f, rounded up to a whole level
    fprod  = (PB'(f) << LVL_BITS) - PB'(f);
    chan   = LVL_BITS'(LVL_MAX) - LVL_BITS'((fprod + PB'(QUARTER - 1)) >> FRAC_BITS);
    bright = data_i.sat ? LVL_BITS'(LVL_MAX) : data_i.root;
  end

  // Divide by 255: exact for products below 2^16
  always_comb begin
    qw_full = (MB+1)'(pw_q) + (MB+1)'(1) + (MB+1)'(pw_q >> LVL_BITS);
    qc_full = (MB+1)'(pc_q) + (MB+1)'(1) + (MB+1)'(pc_q >> LVL_BITS);
    qw      = qw_full[LVL_BITS +: LVL_BITS];
    qc      = qc_full[LVL_BITS +: LVL_BITS];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      warm_raw_q <= data_i.dy_neg ? LVL_BITS'(LVL_MAX) : chan;
      cool_raw_q <= data_i.dy_neg ? chan : LVL_BITS'(LVL_MAX);
      bright1_q  <= bright;
      pw_q       <= MB'(warm_raw_q) * MB'(bright1_q);
      pc_q       <= MB'(cool_raw_q) * MB'(bright1_q);
      bright2_q  <= bright1_q;
      warm_q     <= (qw < low_threshold_i) ? warm_floor_i : qw;
      cool_q     <= (qc < low_threshold_i) ? cool_floor_i : qc;
      bright3_q  <= bright2_q;
    end
  end

  assign valid_o      = v3_q;
  assign warm_level_o = warm_q;
  assign cool_level_o = cool_q;
  assign brightness_o = bright3_q;

endmodule

>>> design/touch_to_white_mix.sv
`timescale 1ns / 1ps

// Touch to white mix: each touch transaction (touch_x_i, touch_y_i) yields one result
// transaction with warm and cool white levels and a brightness equal to the integer
// distance from the configured center, saturated at 255. The angle from the horizontal
// axis sets the warm/cool balance (cool side above the axis, warm side below). The
// datapath is a two stage front end, a chain of CORDIC_STAGES cells (one rotation each,
// plus one square root digit in each of the first SQRT_STEPS) and a three stage back
// end, so a transaction is accepted every clock when the output is not stalled. A
// stall on the output freezes the whole chain, and in_stall_o follows it in the same
// cycle while the output register is full. Configuration registers are written through
// cfg_we_i / cfg_idx_i / cfg_data_i and must only change while no transaction is in
// flight.

module touch_to_white_mix import ttwm_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [COORD_BITS-1:0]   cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [COORD_BITS-1:0]   touch_x_i,
  input  logic [COORD_BITS-1:0]   touch_y_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [LVL_BITS-1:0]     warm_level_o,
  output logic [LVL_BITS-1:0]     cool_level_o,
  output logic [LVL_BITS-1:0]     brightness_o
);

  logic [COORD_BITS-1:0] center_x_q, center_y_q;
  logic [LVL_BITS-1:0]   low_thresh_q, warm_floor_q, cool_floor_q;
  logic                  adv;
  logic                  chain_valid [NUM_CELLS+1];
  cell_t                 chain_data  [NUM_CELLS+1];

  // Whole pipeline moves unless the output holds a stalled result
  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q   <= CENTER_RST;
      center_y_q   <= CENTER_RST;
      low_thresh_q <= LOW_THRESH_RST;
      warm_floor_q <= WARM_FLOOR_RST;
      cool_floor_q <= COOL_FLOOR_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CENTER_X:   center_x_q   <= cfg_data_i;
        CFG_CENTER_Y:   center_y_q   <= cfg_data_i;
        CFG_LOW_THRESH: low_thresh_q <= cfg_data_i[LVL_BITS-1:0];
        CFG_WARM_FLOOR: warm_floor_q <= cfg_data_i[LVL_BITS-1:0];
        CFG_COOL_FLOOR: cool_floor_q <= cfg_data_i[LVL_BITS-1:0];
        default: ;
      endcase
    end
  end

  ttwm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .valid_i    (in_valid_i),
    .touch_x_i  (touch_x_i),
    .touch_y_i  (touch_y_i),
    .center_x_i (center_x_q),
    .center_y_i (center_y_q),
    .valid_o    (chain_valid[0]),
    .data_o     (chain_data[0])
  );

  // Cell chain
  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    ttwm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .idx_i   (IDX_BITS'(g)),
      .valid_i (chain_valid[g]),
      .data_i  (chain_data[g]),
      .valid_o (chain_valid[g+1]),
      .data_o  (chain_data[g+1])
    );
  end

  ttwm_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .adv_i           (adv),
    .valid_i         (chain_valid[NUM_CELLS]),
    .data_i          (chain_data[NUM_CELLS]),
    .low_threshold_i (low_thresh_q),
    .warm_floor_i    (warm_floor_q),
    .cool_floor_i    (cool_floor_q),
    .valid_o         (out_valid_o),
    .warm_level_o    (warm_level_o),
    .cool_level_o    (cool_level_o),
    .brightness_o    (brightness_o)
  );

endmodule

>>> design/ttwm_checker.sv
`timescale 1ns / 1ps

module ttwm_checker import ttwm_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_stall_o,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic [LVL_BITS-1:0]     warm_level_o,
  input logic [LVL_BITS-1:0]     cool_level_o,
  input logic [LVL_BITS-1:0]     brightness_o
);

  // Input stall only comes from a stalled, full output register
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall does not match output backpressure");

  // Reset empties the pipeline and opens the input
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> (!out_valid_o && !in_stall_o))
    else $error("pipeline not empty in reset");

  // A stalled result transaction stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped under stall");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      ($stable(warm_level_o) && $stable(cool_level_o) && $stable(brightness_o)))
    else $error("output payload changed under stall");

endmodule

bind touch_to_white_mix ttwm_checker u_checker (.*);

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import ttwm_pkg::*;

  localparam int ANGLE_STEPS_MAX = 24;
  localparam int DRAIN_CYCLES    = CORDIC_STAGES + 12;
  localparam int STUCK_LIMIT     = 4000;
  localparam int LONG_HOLD       = 150;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
  } touch_t;

  typedef struct packed {
    logic [LVL_BITS-1:0] warm;
    logic [LVL_BITS-1:0] cool;
    logic [LVL_BITS-1:0] bright;
  } mix_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b1;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_idx = '0;
  logic [COORD_BITS-1:0]   cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [COORD_BITS-1:0]   touch_x = '0;
  logic [COORD_BITS-1:0]   touch_y = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [LVL_BITS-1:0]     warm_level;
  logic [LVL_BITS-1:0]     cool_level;
  logic [LVL_BITS-1:0]     brightness;

  // Register copies for the predictor
  logic [COORD_BITS-1:0] center_x_q   = CENTER_RST;
  logic [COORD_BITS-1:0] center_y_q   = CENTER_RST;
  logic [LVL_BITS-1:0]   low_thresh_q = LOW_THRESH_RST;
  logic [LVL_BITS-1:0]   warm_floor_q = WARM_FLOOR_RST;
  logic [LVL_BITS-1:0]   cool_floor_q = COOL_FLOOR_RST;

  // Arctangent of 2^-i, Q16 of a quarter turn
  longint atan_step [ANGLE_STEPS_MAX] = '{
    32768, 19344, 10221, 5188, 2604, 1303, 652, 326,
    163, 81, 41, 20, 10, 5, 3, 1,
    1, 0, 0, 0, 0, 0, 0, 0
  };

  touch_t touch_queue [$];
  mix_t   mix_expected [$];
  touch_t next_touch;
  mix_t   want;
  logic   sender_hold = 1'b0;
  int     send_gap = 0;
  int     calm_sends = 0;
  int     stall_left = 0;
  int     free_left = 0;
  int     results_seen = 0;
  int     stuck_cycles = 0;
  int     fail_count = 0;
  int     pick;

  touch_to_white_mix uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .touch_x_i    (touch_x),
    .touch_y_i    (touch_y),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .warm_level_o (warm_level),
    .cool_level_o (cool_level),
    .brightness_o (brightness)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Expected warm/cool/brightness for one touch under the current registers
  function automatic mix_t mix_for_touch(logic [COORD_BITS-1:0] tx, logic [COORD_BITS-1:0] ty);
    longint dx, dy, ax, ay, sq, root, trial;
    longint x, y, xs, ys, z, chan, bright, warm, cool;
    int     steps;
    mix_t   m;
    dx = longint'(tx) - longint'(center_x_q);
    dy = longint'(ty) - longint'(center_y_q);
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    sq = ax * ax + ay * ay;

    // floor square root, result fits in 13 bits
    root = 0;
    for (int b = 13; b >= 0; b--) begin
      trial = root + (longint'(1) << b);
      if (trial * trial <= sq) root = trial;
    end
    bright = (root > 255) ? 255 : root;

    // vectoring CORDIC on |dx|, |dy|; >>> floors on signed values
    steps = (CORDIC_STAGES > ANGLE_STEPS_MAX) ? ANGLE_STEPS_MAX : CORDIC_STAGES;
    z = 0;
    if (ay == 0) begin
      z = 0;
    end else if (ax == 0) begin
      z = 65536;
    end else begin
      x = ax <<< 16;
      y = ay <<< 16;
      for (int i = 0; i < steps; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + atan_step[i];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - atan_step[i];
        end
      end
      if (z < 0) z = 0;
      if (z > 65536) z = 65536;
    end
    chan = 255 - ((255 * z + 65535) >>> 16);

    if (dy >= 0) begin
      warm = chan;
      cool = 255;
    end else begin
      warm = 255;
      cool = chan;
    end
    warm = warm * bright / 255;
    cool = cool * bright / 255;
    if (warm < longint'(low_thresh_q)) warm = longint'(warm_floor_q);
    if (cool < longint'(low_thresh_q)) cool = longint'(cool_floor_q);
    m.warm   = LVL_BITS'(warm);
    m.cool   = LVL_BITS'(cool);
    m.bright = LVL_BITS'(bright);
    return m;
  endfunction

  // Inter-transaction gap: mostly none, some short, a few long, plus calm runs
  function automatic int pick_send_gap();
    int r;
    if (calm_sends > 0) begin
      calm_sends--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) calm_sends = $urandom_range(30, 120);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Coordinate near a center, or anywhere when that falls off the panel
  function automatic logic [COORD_BITS-1:0] coord_near(logic [COORD_BITS-1:0] c, int span);
    int v;
    v = int'(c) + $urandom_range(0, 2 * span) - span;
    if (v < 0 || v > (1 << COORD_BITS) - 1) return COORD_BITS'($urandom);
    return COORD_BITS'(v);
  endfunction

  task automatic push_touch(int x, int y);
    touch_t t;
    t.x = COORD_BITS'(x);
    t.y = COORD_BITS'(y);
    touch_queue.push_back(t);
  endtask

  task automatic queue_random(int n);
    touch_t t;
    int     r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        t.x = coord_near(center_x_q, 300);
        t.y = coord_near(center_y_q, 300);
      end else if (r < 75) begin
        t.x = coord_near(center_x_q, 25);
        t.y = coord_near(center_y_q, 25);
      end else if (r < 80) begin
        t.x = center_x_q;
        t.y = coord_near(center_y_q, 400);
      end else if (r < 85) begin
        t.x = coord_near(center_x_q, 400);
        t.y = center_y_q;
      end else begin
        t.x = COORD_BITS'($urandom);
        t.y = COORD_BITS'($urandom);
      end
      touch_queue.push_back(t);
    end
  endtask

  // One register write; the caller lowers the enable after its last write
  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [COORD_BITS-1:0] data);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    case (idx)
      CFG_CENTER_X:   center_x_q   = data;
      CFG_CENTER_Y:   center_y_q   = data;
      CFG_LOW_THRESH: low_thresh_q = data[LVL_BITS-1:0];
      CFG_WARM_FLOOR: warm_floor_q = data[LVL_BITS-1:0];
      CFG_COOL_FLOOR: cool_floor_q = data[LVL_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  // Wait until everything sent has come back, then let the pipe drain
  task automatic settle();
    while (touch_queue.size() != 0 || in_valid || mix_expected.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Driver: touch transactions from the pending queue
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) mix_expected.push_back(mix_for_touch(touch_x, touch_y));
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (touch_queue.size() != 0 && !sender_hold) begin
          next_touch = touch_queue.pop_front();
          in_valid <= 1'b1;
          touch_x  <= next_touch.x;
          touch_y  <= next_touch.y;
          send_gap = pick_send_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transaction and drive the output stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (mix_expected.size() == 0) begin
          $error("result with nothing pending: warm %0d cool %0d brightness %0d",
                 warm_level, cool_level, brightness);
          fail_count++;
        end else begin
          want = mix_expected.pop_front();
          if (warm_level !== want.warm) begin
            $error("warm_level: expected %0d, actual %0d", want.warm, warm_level);
            fail_count++;
          end
          if (cool_level !== want.cool) begin
            $error("cool_level: expected %0d, actual %0d", want.cool, cool_level);
            fail_count++;
          end
          if (brightness !== want.bright) begin
            $error("brightness: expected %0d, actual %0d", want.bright, brightness);
            fail_count++;
          end
        end
        results_seen++;
        // long hold-off so the pipe fills and backs up into the input
        if (results_seen == 400 || results_seen == 1500) stall_left = LONG_HOLD;
      end

      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (free_left > 0) begin
        free_left--;
        out_stall <= 1'b0;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 5) free_left = $urandom_range(50, 150);
        else if (pick < 60) free_left = $urandom_range(1, 8);
        else if (pick < 95) stall_left = $urandom_range(1, 3);
        else stall_left = $urandom_range(10, 40);
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: too long without any transaction on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  initial begin
    #1 rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset register values: center at (255, 255)
    push_touch(255, 255);     // at the center
    push_touch(0, 0);
    push_touch(4095, 4095);
    push_touch(0, 4095);
    push_touch(4095, 0);
    push_touch(355, 255);     // on the horizontal axis
    push_touch(155, 255);
    push_touch(255, 355);     // on the vertical axis, above
    push_touch(255, 155);     // on the vertical axis, below
    push_touch(255, 4095);
    push_touch(255, 0);
    push_touch(265, 255);     // dim: levels fall to the floors
    push_touch(255, 262);
    push_touch(250, 250);
    push_touch(355, 355);     // diagonals on both sides of the axis
    push_touch(155, 355);
    push_touch(355, 155);
    push_touch(155, 155);
    push_touch(510, 255);     // distance exactly 255
    push_touch(511, 255);     // just past saturation
    push_touch(300, 400);
    push_touch(200, 100);
    settle();

    // Mid-panel center; the sender pauses halfway until all results are back
    write_reg(CFG_CENTER_X, 12'd2048);
    write_reg(CFG_CENTER_Y, 12'd2048);
    write_reg(CFG_LOW_THRESH, 12'd40);
    write_reg(CFG_WARM_FLOOR, 12'd20);
    write_reg(CFG_COOL_FLOOR, 12'd60);
    end_writes();
    queue_random(500);
    while (touch_queue.size() > 250) @(negedge clk_i);
    sender_hold = 1'b1;
    while (in_valid || mix_expected.size() != 0) @(negedge clk_i);
    sender_hold = 1'b0;
    settle();

    // Corner center, no threshold, floors at max; upper data bits must be masked
    write_reg(CFG_CENTER_X, 12'd0);
    write_reg(CFG_CENTER_Y, 12'd0);
    write_reg(CFG_LOW_THRESH, 12'hF00);
    write_reg(CFG_WARM_FLOOR, 12'hFFF);
    write_reg(CFG_COOL_FLOOR, 12'h0FF);
    // unused indexes: writes must be dropped
    for (int k = int'(CFG_COOL_FLOOR) + 1; k < (1 << CFG_IDX_BITS); k++)
      write_reg(CFG_IDX_BITS'(k), COORD_BITS'($urandom));
    end_writes();
    queue_random(400);
    settle();

    // Far corner, threshold at max so every level below 255 takes the floor
    write_reg(CFG_CENTER_X, 12'd4095);
    write_reg(CFG_CENTER_Y, 12'd4095);
    write_reg(CFG_LOW_THRESH, 12'hAFF);
    write_reg(CFG_WARM_FLOOR, 12'h500);
    write_reg(CFG_COOL_FLOOR, 12'h000);
    end_writes();
    queue_random(400);
    settle();

    // Random settings
    for (int p = 0; p < 3; p++) begin
      write_reg(CFG_CENTER_X, COORD_BITS'($urandom));
      write_reg(CFG_CENTER_Y, COORD_BITS'($urandom));
      write_reg(CFG_LOW_THRESH, COORD_BITS'({$urandom_range(0, 15), 8'($urandom_range(0, 90))}));
      write_reg(CFG_WARM_FLOOR, COORD_BITS'($urandom));
      write_reg(CFG_COOL_FLOOR, COORD_BITS'($urandom));
      end_writes();
      queue_random(250);
      settle();
    end

    if (mix_expected.size() != 0) begin
      $error("%0d results never arrived", mix_expected.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/ttwm_pkg.sv
design/ttwm_front.sv
design/ttwm_cell.sv
design/ttwm_back.sv
design/touch_to_white_mix.sv
design/ttwm_checker.sv
bench/testbench.sv
